// ----- hw/rtl/mavg_pkg.sv -----
// Package for the moving average / standard deviation block.
// Widths, limits and shared types; no dependencies.
`default_nettype none
package mavg_pkg;
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int SLOT_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = SAMPLE_BITS + SLOT_W;
  localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
  localparam int SQS_W   = SQ_W + SLOT_W;
  localparam int PROD_W  = SQS_W + CNT_W;
  localparam int RAD_W   = ((PROD_W + 16) % 2 == 0) ? PROD_W + 16 : PROD_W + 17;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int NUM_W   = SUM_W + 8;
  localparam int DIV_W   = (NUM_W > ROOT_W) ? NUM_W : ROOT_W;
  localparam int AVG_W   = 24;
  localparam int STD_W   = 24;
  localparam logic [CNT_W-1:0] WL_RESET = CNT_W'(16);
endpackage
`default_nettype wire

// ----- hw/rtl/mavg_ring.sv -----
// Sample ring: synchronous memory, one write and one registered read port.
// Depends on mavg_pkg.
`default_nettype none
module mavg_ring
  import mavg_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [SLOT_W-1:0]             waddr,
  input  wire logic signed [SAMPLE_BITS-1:0] wdata,
  input  wire logic [SLOT_W-1:0]             raddr,
  output logic signed [SAMPLE_BITS-1:0]      rdata
);
  logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mavg_sqrt.sv -----
// Iterative integer square root, one root bit per cycle.
// Depends on mavg_pkg.
`default_nettype none
module mavg_sqrt
  import mavg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  rad,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);
  localparam int IT_W = $clog2(ROOT_W + 1);
  logic [RAD_W-1:0]   rad_r;
  logic [ROOT_W+1:0]  rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [IT_W-1:0]    it_r;
  logic               busy_r, done_r;
  logic [ROOT_W+1:0]  rem_sh, trial;

  assign rem_sh = {rem_r[ROOT_W-1:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      it_r   <= IT_W'(ROOT_W);
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= rad_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
      it_r <= it_r - 1'b1;
      if (it_r == IT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

// ----- hw/rtl/mavg_div.sv -----
// Restoring divider, one quotient bit per cycle, divisor is the sample count.
// Depends on mavg_pkg.
`default_nettype none
module mavg_div
  import mavg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [CNT_W-1:0]  divisor,
  output logic                   done,
  output logic [DIV_W-1:0]       quot,
  output logic                   rem_nz
);
  localparam int IT_W = $clog2(DIV_W + 1);
  logic [DIV_W-1:0] q_r;
  logic [CNT_W:0]   rem_r, rem_sh;
  logic [CNT_W-1:0] d_r;
  logic [IT_W-1:0]  it_r;
  logic             busy_r, done_r;

  assign rem_sh = {rem_r[CNT_W-1:0], q_r[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      it_r   <= IT_W'(DIV_W);
      q_r    <= dividend;
      d_r    <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, d_r}) begin
        rem_r <= rem_sh - {1'b0, d_r};
        q_r   <= {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[DIV_W-2:0], 1'b0};
      end
      it_r <= it_r - 1'b1;
      if (it_r == IT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done   = done_r;
  assign quot   = q_r;
  assign rem_nz = (rem_r != '0);
endmodule
`default_nettype wire

// ----- hw/rtl/moving_average_stddev.sv -----
// Top level: moving average and population standard deviation over a ring.
// Depends on mavg_pkg, mavg_ring, mavg_sqrt, mavg_div.
//
// Usage:
//  - in_*: one beat per item. in_tuser = func (0 add sample, 1 clear window),
//    in_tdata = signed Q8.8 sample (ignored on clear).
//  - out_*: one beat per item. out_tdata = {pad, fill_count, std_dev, average},
//    out_tuser = valid_res (window holds at least one sample).
//  - cfg_wr_en / cfg_wr_data set the window length (0 acts as 1, above 64 acts
//    as 64) and empty the window. Write only while the block is idle; in_tready
//    is low in the write cycle.
// Timing:
//  - An added sample's result is valid after ring read, squaring, sum update,
//    n*S2 and S1*S1 products, a handoff state, then a 30-step square root
//    followed by a 30-step divide by n; the average divide runs alongside
//    the root.
//  - A clear item empties the window and goes straight to the final state.
//  - One item is in flight at a time; the input is ready again as soon as the
//    result sits in the output register, so the next item's work overlaps a
//    stalled receiver.
// Reset: window length back to 16, window empty, no beat pending.
// Stall: a finished result waits in the output register; a following result
//  waits in its final state until the output register is taken.
`default_nettype none
module moving_average_stddev
  import mavg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,   // [15:0] sample
  input  wire logic              in_tuser,   // [0] func
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [55:0]            out_tdata,  // [23:0] average, [47:24] std_dev,
                                             // [54:48] fill_count, [55] zero
  output logic                   out_tuser,  // [0] valid_res
  input  wire logic              cfg_wr_en,
  input  wire logic [CNT_W-1:0]  cfg_wr_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_SQ, S_UPD, S_MUL, S_VAR, S_ROOT, S_DIV, S_DONE
  } state_t;

  state_t state_r;

  // window state
  logic [CNT_W-1:0]              wl_r;
  logic [SLOT_W-1:0]             slot_r;
  logic [CNT_W-1:0]              held_r;
  logic signed [SUM_W-1:0]       s1_r;
  logic [SQS_W-1:0]              s2_r;

  // per-item datapath
  logic signed [SAMPLE_BITS-1:0] sample_r, old_r;
  logic                          full_r;
  logic [SQ_W-1:0]               sq_new_r, sq_old_r;
  logic [PROD_W-1:0]             a_r, b_r;
  logic                          neg_r;

  // output register
  logic                          out_valid_r;
  logic [AVG_W-1:0]              avg_out_r;
  logic [STD_W-1:0]              std_out_r;
  logic                          vres_out_r;
  logic [CNT_W-1:0]              cnt_out_r;

  logic signed [SAMPLE_BITS-1:0] ring_rdata;
  logic                          ring_we;
  logic [SUM_W-1:0]              s1_mag;
  logic [RAD_W-1:0]              rad;
  logic                          sq_done, avg_done, std_done, avg_rnz, std_rnz;
  logic [ROOT_W-1:0]             root;
  logic [DIV_W-1:0]              avg_q, std_q;
  logic                          root_start, std_start, out_free;
  logic [DIV_W:0]                avg_mag;
  logic signed [DIV_W:0]         avg_signed;
  logic [CNT_W-1:0]              wl_clamped;

  assign s1_mag   = s1_r[SUM_W-1] ? SUM_W'(-s1_r) : SUM_W'(s1_r);
  assign rad      = (a_r >= b_r) ? RAD_W'({a_r - b_r, 16'h0000}) : '0;
  assign ring_we  = (state_r == S_UPD);
  assign root_start = (state_r == S_VAR);
  assign std_start  = (state_r == S_ROOT) && sq_done;
  assign out_free   = !out_valid_r || out_tready;

  // floor for negative means: round magnitude up when a remainder is left
  assign avg_mag    = {1'b0, avg_q} + (DIV_W+1)'(neg_r && avg_rnz);
  assign avg_signed = neg_r ? -$signed(avg_mag) : $signed(avg_mag);

  always_comb begin
    wl_clamped = cfg_wr_data;
    if (cfg_wr_data == '0) begin
      wl_clamped = CNT_W'(1);
    end else if (cfg_wr_data > CNT_W'(MAX_WINDOW)) begin
      wl_clamped = CNT_W'(MAX_WINDOW);
    end
  end

  mavg_ring u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot_r),
    .wdata (sample_r),
    .raddr (slot_r),
    .rdata (ring_rdata)
  );

  mavg_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .rad   (rad),
    .done  (sq_done),
    .root  (root)
  );

  mavg_div u_div_avg (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .dividend (DIV_W'({s1_mag, 8'h00})),
    .divisor  (held_r),
    .done     (avg_done),
    .quot     (avg_q),
    .rem_nz   (avg_rnz)
  );

  mavg_div u_div_std (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (std_start),
    .dividend (DIV_W'(root)),
    .divisor  (held_r),
    .done     (std_done),
    .quot     (std_q),
    .rem_nz   (std_rnz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wl_r        <= WL_RESET;
      slot_r      <= '0;
      held_r      <= '0;
      s1_r        <= '0;
      s2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        wl_r   <= wl_clamped;
        slot_r <= '0;
        held_r <= '0;
        s1_r   <= '0;
        s2_r   <= '0;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (in_tvalid) begin
              if (in_tuser) begin
                slot_r  <= '0;
                held_r  <= '0;
                s1_r    <= '0;
                s2_r    <= '0;
                state_r <= S_DONE;
              end else begin
                sample_r <= in_tdata;
                full_r   <= (held_r == wl_r);
                state_r  <= S_RD;
              end
            end
          end
          S_RD: begin
            old_r    <= ring_rdata;
            sq_new_r <= SQ_W'(sample_r) * SQ_W'(sample_r);
            state_r  <= S_SQ;
          end
          S_SQ: begin
            sq_old_r <= SQ_W'(old_r) * SQ_W'(old_r);
            state_r  <= S_UPD;
          end
          S_UPD: begin
            if (full_r) begin
              s1_r <= s1_r + SUM_W'(sample_r) - SUM_W'(old_r);
              s2_r <= s2_r + SQS_W'(sq_new_r) - SQS_W'(sq_old_r);
            end else begin
              s1_r   <= s1_r + SUM_W'(sample_r);
              s2_r   <= s2_r + SQS_W'(sq_new_r);
              held_r <= held_r + 1'b1;
            end
            slot_r  <= (CNT_W'(slot_r) + 1'b1 == wl_r) ? '0 : slot_r + 1'b1;
            state_r <= S_MUL;
          end
          S_MUL: begin
            a_r     <= PROD_W'(held_r) * PROD_W'(s2_r);
            b_r     <= PROD_W'(s1_mag) * PROD_W'(s1_mag);
            neg_r   <= s1_r[SUM_W-1];
            state_r <= S_VAR;
          end
          S_VAR: begin
            state_r <= S_ROOT;
          end
          S_ROOT: begin
            if (sq_done) begin
              state_r <= S_DIV;
            end
          end
          S_DIV: begin
            if (std_done && avg_done) begin
              state_r <= S_DONE;
            end
          end
          S_DONE: begin
            if (out_free) begin
              out_valid_r <= 1'b1;
              vres_out_r  <= (held_r != '0);
              cnt_out_r   <= held_r;
              if (held_r == '0) begin
                avg_out_r <= '0;
                std_out_r <= '0;
              end else begin
                avg_out_r <= AVG_W'(avg_signed);
                std_out_r <= STD_W'(std_q);
              end
              state_r <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE) && !cfg_wr_en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, cnt_out_r, std_out_r, avg_out_r};
  assign out_tuser  = vres_out_r;

  // remainder of the root divide is not needed: the deviation is floored
  logic unused_std_rnz;
  assign unused_std_rnz = std_rnz;
endmodule
`default_nettype wire

// ----- hw/rtl/mavg_checker.sv -----
// Port-level checks for moving_average_stddev, bound to the top level.
// Depends on mavg_pkg.
`default_nettype none
module mavg_checker
  import mavg_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic        out_tuser
);
  a_vres_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[54:48] != 7'd0)))
    else $error("valid_res disagrees with fill_count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[47:0] == 48'd0))
    else $error("empty window result not zero");

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[54:48] <= 7'(MAX_WINDOW)))
    else $error("fill_count above window limit");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output beat changed");
endmodule

bind moving_average_stddev mavg_checker u_mavg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
